[rtl/core/rpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpe_pkg
// Types and constants of the rotation period estimator.
// ----------------------------------------------------------------------------
package rpe_pkg;

    localparam logic [19:0] NOMINAL_RESET = 20'd200000;
    localparam logic [6:0]  DIV_STEPS     = 7'd64;
    localparam logic [1:0]  MUL_LAST_PH   = 2'd2;

    typedef struct packed {
        logic        op;
        logic [47:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic        [31:0] rotations;
        logic signed [31:0] period_overall;
        logic signed [31:0] period_recent;
        logic        [31:0] missed;
    } t_out_item;

    typedef struct packed {
        logic [31:0] rot;
        logic [47:0] tim;
        logic [63:0] rt;
        logic [63:0] rr;
    } t_win_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_MUL,
        S_SUM,
        S_DEN,
        S_DIV,
        S_DIVEND,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        DIV_EXTRA,
        DIV_OV,
        DIV_WIN
    } t_div_sel;

    typedef enum logic [3:0] {
        MUL_RT,
        MUL_RR,
        MUL_OV_XT,
        MUL_OV_XST,
        MUL_OV_XX,
        MUL_OV_SXX,
        MUL_WN_XT,
        MUL_WN_XST,
        MUL_WN_XX,
        MUL_WN_SXX
    } t_mul_sel;

    localparam logic OP_START = 1'b0;
    localparam logic OP_EVENT = 1'b1;

endpackage

[rtl/core/rotation_period_estimator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_period_estimator_unit
// Least-squares rotation period estimator over all points and over a window.
// ----------------------------------------------------------------------------
// Start item: no result. Event: the result is set by up to three 64-step serial
// divisions (missed rotations, overall, window; one skipped for each zero
// denominator) and ten 64-bit products on one 32x32 multiplier. One item at
// a time: input stalls until the result is loaded, so no new event is taken
// while the previous one is still in progress.
// Reset (synchronous, active low) loads the start state at time zero.
// ----------------------------------------------------------------------------
module rotation_period_estimator_unit #(
    parameter int WINDOW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rpe_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rpe_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [19:0]        i_cfg_data
);
    import rpe_pkg::*;

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
    localparam logic [63:0]   WIN_CNT  = 64'(WINDOW);

    t_state   r_state, n_state;
    t_div_sel r_div_sel;
    t_mul_sel r_mul_idx;
    logic [1:0] r_mul_ph;
    logic [6:0] r_div_cnt;

    logic [19:0] r_nominal;
    logic [47:0] r_start, r_prev, r_ts;
    logic [63:0] r_pe, r_held;
    logic [31:0] r_rc, r_missed, r_cnt, r_rot;
    logic [63:0] r_sx, r_st, r_sxt, r_sxx;
    logic [63:0] r_wx, r_wt, r_wxt, r_wxx;
    logic [PW-1:0] r_pos;
    logic [WINDOW-1:0] r_vld;

    t_win_entry mem [WINDOW];
    t_win_entry r_rd;
    logic       r_rd_vld;

    logic [47:0] r_t;
    logic [63:0] r_acc, r_p0, r_p1, r_even, r_num, r_den;
    logic [63:0] r_rem, r_quo, r_dvs;
    logic        r_div_neg;

    logic        r_out_valid;
    t_out_item   r_out;

    logic accept, is_start, out_free;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign accept   = i_in_valid && !o_in_stall;
    assign is_start = (i_in_data.op == OP_START);
    assign out_free = !r_out_valid || !i_out_stall;

    function automatic logic [63:0] half_s(input logic [63:0] x);
        logic [63:0] tmp;
        tmp = x + {63'b0, x[63]};
        return {tmp[63], tmp[63:1]};
    endfunction

    // ---- check stage
    logic [47:0] c_t, c_gap;
    logic [63:0] c_pe3, c_thr, c_num;
    logic        c_miss;
    always_comb begin
        c_t    = r_ts - r_start;
        c_gap  = r_ts - r_prev;
        c_pe3  = r_pe + {r_pe[62:0], 1'b0};
        c_thr  = half_s(c_pe3);
        c_num  = {16'b0, c_gap} - half_s(r_pe);
        c_miss = (r_pe != 64'd0) && ($signed({16'b0, c_gap}) > $signed(c_thr));
    end

    // ---- shared multiplier
    logic [63:0] m_a, m_b, m_part, m_res;
    logic [31:0] m_x, m_y;
    always_comb begin
        unique case (r_mul_idx)
            MUL_RT:     begin m_a = {32'b0, r_rot}; m_b = {16'b0, r_t}; end
            MUL_RR:     begin m_a = {32'b0, r_rot}; m_b = {32'b0, r_rot}; end
            MUL_OV_XT:  begin m_a = {32'b0, r_cnt}; m_b = r_sxt; end
            MUL_OV_XST: begin m_a = r_sx;           m_b = r_st; end
            MUL_OV_XX:  begin m_a = {32'b0, r_cnt}; m_b = r_sxx; end
            MUL_OV_SXX: begin m_a = r_sx;           m_b = r_sx; end
            MUL_WN_XT:  begin m_a = WIN_CNT;        m_b = r_wxt; end
            MUL_WN_XST: begin m_a = r_wx;           m_b = r_wt; end
            MUL_WN_XX:  begin m_a = WIN_CNT;        m_b = r_wxx; end
            MUL_WN_SXX: begin m_a = r_wx;           m_b = r_wx; end
            default:    begin m_a = '0;             m_b = '0; end
        endcase
        unique case (r_mul_ph)
            2'd0:    begin m_x = m_a[31:0];  m_y = m_b[31:0]; end
            2'd1:    begin m_x = m_a[31:0];  m_y = m_b[63:32]; end
            default: begin m_x = m_a[63:32]; m_y = m_b[31:0]; end
        endcase
        m_part = {32'b0, m_x} * {32'b0, m_y};
        if (r_mul_ph == 2'd0) begin
            m_res = m_part;
        end else begin
            m_res = r_acc + {m_part[31:0], 32'b0};
        end
    end

    // ---- divider step
    logic [64:0] d_sh;
    logic        d_ge;
    logic [63:0] d_q;
    always_comb begin
        d_sh = {r_rem, r_quo[63]};
        d_ge = (d_sh >= {1'b0, r_dvs});
        d_q  = r_div_neg ? (64'd0 - r_quo) : r_quo;
    end

    t_win_entry w_old, w_new;
    always_comb begin
        w_old     = r_rd_vld ? r_rd : '0;
        w_new.rot = r_rot;
        w_new.tim = r_t;
        w_new.rt  = r_p0;
        w_new.rr  = r_p1;
    end

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept && !is_start) n_state = S_CHK;
            S_CHK:    n_state = c_miss ? S_DIV : S_MUL;
            S_MUL: begin
                if (r_mul_ph == MUL_LAST_PH) begin
                    if (r_mul_idx == MUL_RR) begin
                        n_state = S_SUM;
                    end else if (r_mul_idx == MUL_OV_SXX || r_mul_idx == MUL_WN_SXX) begin
                        n_state = S_DEN;
                    end
                end
            end
            S_SUM:    n_state = S_MUL;
            S_DEN: begin
                if (r_den != 64'd0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = (r_mul_idx == MUL_WN_SXX) ? S_FIN : S_MUL;
                end
            end
            S_DIV:    if (r_div_cnt == 7'd1) n_state = S_DIVEND;
            S_DIVEND: n_state = (r_div_sel == DIV_WIN) ? S_FIN : S_MUL;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---- control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nominal   <= NOMINAL_RESET;
            r_start     <= '0;
            r_prev      <= '0;
            r_pe        <= {44'b0, NOMINAL_RESET};
            r_held      <= '0;
            r_rc        <= '0;
            r_missed    <= '0;
            r_cnt       <= 32'd1;
            r_sx        <= '0;
            r_st        <= '0;
            r_sxt       <= '0;
            r_sxx       <= '0;
            r_wx        <= '0;
            r_wt        <= '0;
            r_wxt       <= '0;
            r_wxx       <= '0;
            r_pos       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_mul_idx   <= MUL_RT;
            r_mul_ph    <= '0;
            r_div_cnt   <= '0;
            r_div_sel   <= DIV_EXTRA;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_nominal <= i_cfg_data;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && is_start) begin
                        r_start  <= i_in_data.timestamp;
                        r_prev   <= i_in_data.timestamp;
                        r_pe     <= {44'b0, r_nominal};
                        r_held   <= '0;
                        r_rc     <= '0;
                        r_missed <= '0;
                        r_cnt    <= 32'd1;
                        r_sx     <= '0;
                        r_st     <= '0;
                        r_sxt    <= '0;
                        r_sxx    <= '0;
                        r_wx     <= '0;
                        r_wt     <= '0;
                        r_wxt    <= '0;
                        r_wxx    <= '0;
                        r_pos    <= '0;
                        r_vld    <= '0;
                    end
                end
                S_CHK: begin
                    r_prev    <= r_ts;
                    r_mul_idx <= MUL_RT;
                    r_mul_ph  <= '0;
                    r_div_cnt <= DIV_STEPS;
                    r_div_sel <= DIV_EXTRA;
                end
                S_MUL: begin
                    if (r_mul_ph == MUL_LAST_PH) begin
                        r_mul_ph <= '0;
                        if (r_mul_idx != MUL_OV_SXX && r_mul_idx != MUL_WN_SXX) begin
                            r_mul_idx <= t_mul_sel'(r_mul_idx + 4'd1);
                        end
                    end else begin
                        r_mul_ph <= r_mul_ph + 2'd1;
                    end
                end
                S_SUM: begin
                    r_rc  <= r_rot;
                    r_cnt <= r_cnt + 32'd1;
                    r_sx  <= r_sx + {32'b0, r_rot};
                    r_st  <= r_st + {16'b0, r_t};
                    r_sxt <= r_sxt + r_p0;
                    r_sxx <= r_sxx + r_p1;
                    r_wx  <= r_wx + {32'b0, r_rot} - {32'b0, w_old.rot};
                    r_wt  <= r_wt + {16'b0, r_t} - {16'b0, w_old.tim};
                    r_wxt <= r_wxt + r_p0 - w_old.rt;
                    r_wxx <= r_wxx + r_p1 - w_old.rr;
                    r_vld[r_pos] <= 1'b1;
                    r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
                end
                S_DEN: begin
                    r_div_cnt <= DIV_STEPS;
                    r_div_sel <= (r_mul_idx == MUL_WN_SXX) ? DIV_WIN : DIV_OV;
                    if (r_den == 64'd0 && r_mul_idx == MUL_OV_SXX) begin
                        r_mul_idx <= MUL_WN_XT;
                    end
                end
                S_DIV: r_div_cnt <= r_div_cnt - 7'd1;
                S_DIVEND: begin
                    unique case (r_div_sel)
                        DIV_EXTRA: begin
                            r_missed  <= r_missed + d_q[31:0];
                            r_mul_idx <= MUL_RT;
                        end
                        DIV_OV: begin
                            r_pe      <= d_q;
                            r_mul_idx <= MUL_WN_XT;
                        end
                        default: r_held <= d_q;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // ---- datapath temporaries
    always_ff @(posedge i_clk) begin
        r_rd     <= mem[r_pos];
        r_rd_vld <= r_vld[r_pos];
        if (r_state == S_SUM) mem[r_pos] <= w_new;
        if (accept) r_ts <= i_in_data.timestamp;
        if (r_state == S_CHK) begin
            r_t   <= c_t;
            r_rot <= r_rc + 32'd1;
            if (c_miss) begin
                r_div_neg <= c_num[63] ^ r_pe[63];
                r_quo     <= c_num[63] ? (64'd0 - c_num) : c_num;
                r_dvs     <= r_pe[63] ? (64'd0 - r_pe) : r_pe;
                r_rem     <= '0;
            end
        end
        if (r_state == S_DEN) begin
            r_div_neg <= r_num[63] ^ r_den[63];
            r_quo     <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_dvs     <= r_den[63] ? (64'd0 - r_den) : r_den;
            r_rem     <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= d_ge ? 64'(d_sh - {1'b0, r_dvs}) : d_sh[63:0];
            r_quo <= {r_quo[62:0], d_ge};
        end
        if (r_state == S_DIVEND && r_div_sel == DIV_EXTRA) begin
            r_rot <= r_rot + d_q[31:0];
        end
        if (r_state == S_MUL) begin
            r_acc <= m_res;
            if (r_mul_ph == MUL_LAST_PH) begin
                unique case (r_mul_idx)
                    MUL_RT: r_p0 <= m_res;
                    MUL_RR: r_p1 <= m_res;
                    MUL_OV_XST, MUL_WN_XST: r_num <= r_even - m_res;
                    MUL_OV_SXX, MUL_WN_SXX: r_den <= r_even - m_res;
                    default: r_even <= m_res;
                endcase
            end
        end
        if (r_state == S_FIN && out_free) begin
            r_out.rotations      <= r_rc;
            r_out.period_overall <= r_pe[31:0];
            r_out.period_recent  <= r_held[31:0];
            r_out.missed         <= r_missed;
        end
    end

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_cnt != 7'd0))
        else $error("divider running with zero step count");
    a_event_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_start) |=> (r_state == S_CHK))
        else $error("accepted event did not enter check");
    a_mul_ph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mul_ph <= MUL_LAST_PH))
        else $error("multiplier phase out of range");
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_LAST))
        else $error("window position out of range");
    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> o_out_valid)
        else $error("finished result not presented");

endmodule

[dv/rotation_period_estimator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_period_estimator_unit_tb
// Self-checking bench: a directed table, then random rotation sequences
// (regular spin, skipped rotations, noise), checked against a behavioral
// least-squares period predictor with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module rotation_period_estimator_unit_tb;
    import rpe_pkg::*;

    localparam int  WIN        = 16;
    localparam int  LIMIT      = 1000000;
    localparam int  DRAIN      = 300;
    localparam logic [63:0] M32    = 64'hFFFF_FFFF;
    localparam logic [63:0] SMIN   = 64'h8000_0000_0000_0000;

    typedef struct {
        logic        op;
        logic [47:0] ts;
        bit          typed;
        t_out_item   res;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_data;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [19:0] cfg_data;

    rotation_period_estimator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    // predictor state
    logic [63:0] nominal, est, rot_cnt, miss_cnt, pts;
    logic [63:0] s_r, s_t, s_rt, s_rr, win_held;
    logic [47:0] t_base, t_prev;
    logic [63:0] win_r [WIN];
    logic [63:0] win_t [WIN];
    int          win_pos;

    t_out_item   pending_periods [$];
    int          errors = 0;
    int          cycles = 0;
    bit          gaps_on = 1;
    logic        long_hold;
    t_row        table_rows [$];

    function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
        if (a == SMIN && b == '1) return a;
        return $signed(a) / $signed(b);
    endfunction

    function automatic bit ls_slope(logic [63:0] n, logic [63:0] sx, logic [63:0] st,
                                    logic [63:0] sxt, logic [63:0] sxx,
                                    output logic [63:0] q);
        logic [63:0] num, den;
        num = n * sxt - sx * st;
        den = n * sxx - sx * sx;
        q = 0;
        if (den == 0) return 0;
        q = div_trunc(num, den);
        return 1;
    endfunction

    task automatic restart_spin(logic [47:0] ts);
        t_base = ts; t_prev = ts; est = nominal;
        rot_cnt = 0; miss_cnt = 0; pts = 1;
        s_r = 0; s_t = 0; s_rt = 0; s_rr = 0;
        for (int i = 0; i < WIN; i++) begin
            win_r[i] = 0; win_t[i] = 0;
        end
        win_pos = 0; win_held = 0;
    endtask

    function automatic t_out_item predict_rotation(logic [47:0] ts);
        logic [63:0] rot, t, gap, extra, q, wx, wt, wxt, wxx;
        t_out_item r;
        rot = (rot_cnt + 1) & M32;
        t   = {16'b0, ts - t_base};
        gap = {16'b0, ts - t_prev};
        if (est != 0) begin
            if ($signed(gap) > $signed(div_trunc(est * 3, 2))) begin
                extra = div_trunc(gap - div_trunc(est, 2), est);
                rot = (rot + extra) & M32;
                miss_cnt = (miss_cnt + extra) & M32;
            end
        end
        rot_cnt = rot;
        t_prev = ts;
        win_r[win_pos] = rot;
        win_t[win_pos] = t;
        s_r += rot; s_t += t; s_rt += rot * t; s_rr += rot * rot;
        pts = (pts + 1) & M32;
        if (ls_slope(pts, s_r, s_t, s_rt, s_rr, q)) est = q;
        wx = 0; wt = 0; wxt = 0; wxx = 0;
        for (int i = 0; i < WIN; i++) begin
            wx += win_r[i]; wt += win_t[i];
            wxt += win_r[i] * win_t[i]; wxx += win_r[i] * win_r[i];
        end
        if (ls_slope(64'(WIN), wx, wt, wxt, wxx, q)) win_held = q;
        win_pos = (win_pos + 1) % WIN;
        r.rotations = rot_cnt[31:0];
        r.period_overall = est[31:0];
        r.period_recent = win_held[31:0];
        r.missed = miss_cnt[31:0];
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("rotation_period_estimator_unit verification failed");
            $finish;
        end
    end

    // receiver stall pattern
    int hold_left = 0;
    int mode_left = 0;
    int mode = 0;
    int pat = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (long_hold && hold_left == 0) begin
            hold_left <= 3000;
            out_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            if (hold_left == 1) hold_left <= 0;
            if (mode_left == 0) begin
                mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(100, 600);
            end else begin
                mode_left <= mode_left - 1;
            end
            pat <= pat + 1;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 40);
                default: out_stall <= (pat % 7) < 3;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_periods.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                t_out_item e;
                e = pending_periods.pop_front();
                if (out_data.rotations !== e.rotations) begin
                    $error("rotations exp %0d got %0d", e.rotations, out_data.rotations);
                    errors++;
                end
                if (out_data.period_overall !== e.period_overall) begin
                    $error("period_overall exp %0d got %0d", e.period_overall,
                           out_data.period_overall);
                    errors++;
                end
                if (out_data.period_recent !== e.period_recent) begin
                    $error("period_recent exp %0d got %0d", e.period_recent,
                           out_data.period_recent);
                    errors++;
                end
                if (out_data.missed !== e.missed) begin
                    $error("missed exp %0d got %0d", e.missed, out_data.missed);
                    errors++;
                end
            end
        end
    end

    int burst_left = 0;

    task automatic send_item(logic op, logic [47:0] ts, bit typed, t_out_item tv);
        t_out_item p;
        int g;
        in_valid <= 1'b1;
        in_data <= '{op: op, timestamp: ts};
        do @(posedge i_clk); while (in_stall);
        if (op == OP_START) begin
            restart_spin(ts);
        end else begin
            p = predict_rotation(ts);
            pending_periods.push_back(typed ? tv : p);
        end
        g = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                g = $urandom_range(1, 20);
                burst_left = $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_periods.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_nominal(logic [19:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        nominal = {44'b0, v};
    endtask

    task automatic random_spin(int n, logic [19:0] per);
        logic [47:0] ts;
        int k;
        ts = 48'({$urandom, $urandom});
        send_item(OP_START, ts, 0, '0);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 70) ts += 48'(per) + 48'($urandom_range(0, 40)) - 48'd20;
            else if (k < 85) ts += 48'(per) * 48'($urandom_range(2, 5))
                                   + 48'($urandom_range(0, 99));
            else if (k < 92) ts += 48'($urandom_range(0, 3));
            else ts = 48'({$urandom, $urandom});
            send_item(($urandom_range(0, 49) == 0) ? OP_START : OP_EVENT, ts, 0, '0);
        end
    endtask

    initial begin
        logic [19:0] per;
        t_row r;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        long_hold = 1'b0;
        nominal = {44'b0, NOMINAL_RESET};
        restart_spin(48'd0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        table_rows = '{
            '{OP_EVENT, 48'd200000, 1, '{32'd1, 32'sd200000, 32'sd200000, 32'd0}},
            '{OP_START, 48'd0, 0, '0},
            '{OP_EVENT, 48'd200000, 1, '{32'd1, 32'sd200000, 32'sd200000, 32'd0}},
            '{OP_EVENT, 48'd400000, 0, '0},
            '{OP_EVENT, 48'd1200000, 0, '0},
            '{OP_EVENT, 48'd1200000, 0, '0},
            '{OP_EVENT, 48'd1200001, 0, '0},
            '{OP_EVENT, 48'hFFFF_FFFF_FFFF, 0, '0},
            '{OP_START, 48'hFFFF_FFFF_FFFF, 0, '0},
            '{OP_EVENT, 48'd199999, 0, '0},
            '{OP_EVENT, 48'd399999, 0, '0},
            '{OP_EVENT, 48'h7FFF_FFFF_FFFF, 0, '0},
            '{OP_EVENT, 48'h0, 0, '0},
            '{OP_START, 48'h8000_0000_0000, 0, '0},
            '{OP_EVENT, 48'h8000_0000_0000, 0, '0},
            '{OP_EVENT, 48'h8000_0000_0000, 0, '0},
            '{OP_EVENT, 48'h8000_0003_0D40, 0, '0},
            '{OP_EVENT, 48'h5555_5555_5555, 0, '0},
            '{OP_EVENT, 48'hAAAA_AAAA_AAAA, 0, '0}
        };
        foreach (table_rows[i]) begin
            r = table_rows[i];
            send_item(r.op, r.ts, r.typed, r.res);
        end
        drain();

        write_nominal(20'd1);
        random_spin(40, 20'd1);
        drain();
        write_nominal(20'd1000000);
        gaps_on = 0;
        random_spin(40, 20'd1000000);
        gaps_on = 1;
        drain();

        long_hold <= 1'b1;
        @(posedge i_clk);
        long_hold <= 1'b0;
        random_spin(30, 20'd1000000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            per = 20'($urandom_range(1, 1000000));
            write_nominal(per);
            random_spin(60, per);
            drain();
        end

        if (errors == 0) begin
            $display("rotation_period_estimator_unit verification clean");
        end else begin
            $display("rotation_period_estimator_unit verification failed");
        end
        $finish;
    end
endmodule
